[rtl/qdf_pkg.sv]
package qdf_pkg;

  // Configuration port geometry.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_AREA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_DENSITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPLOY_AT   = 3'd6;

  // Register values after reset.
  localparam logic [15:0] RST_DRAG_COEFF  = 16'd4096;
  localparam logic [23:0] RST_REF_AREA    = 24'd4096;
  localparam logic [15:0] RST_AIR_DENSITY = 16'd20070;
  localparam logic [2:0]  RST_DEPLOY_AT   = 3'd1;

  // Input word: one simulation tick.
  typedef struct packed {
    logic               kind;
    logic [2:0]         vehicle_state;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } in_word_t;

  // Output word: body-frame drag force and the latch.
  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               is_deployed;
  } out_word_t;

endpackage

[rtl/quadratic_drag_force_with_deploy_latch.sv]
// Channel   Direction  Ports
// input     in         in_valid, in_stall, in_data
// result    out        out_valid, out_stall, out_data
// config    in         cfg_we, cfg_index, cfg_wdata
//
// A deployed word goes through the multiply and square-root sequence before its
// result reaches the output register; a word that leaves the latch clear goes straight there.
// The work is done by one shared 32x32 multiplier (65 limb products in all)
// and a square root that retires one result bit per cycle.
// Reset is synchronous and active low; it restores the registers and clears the latch.
// in_stall is high while a word is in work; a finished word waits in the output
// register while out_stall is high, and the next word can already be accepted.
module quadratic_drag_force_with_deploy_latch (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  qdf_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output qdf_pkg::out_word_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [qdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qdf_pkg::CFG_W-1:0]            cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_K1, S_K2, S_P, S_F, S_Q, S_R, S_B,
    S_DRAIN, S_END, S_DONE
  } state_t;

  localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;
  localparam logic [46:0]        MAX_MAG47 = {47{1'b1}};
  localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};

  // Saturating Q16.16 subtract.
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sub_sat = d[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      sub_sat = d[31:0];
    end
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    mag32 = a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic [35:0] mag37(input logic signed [36:0] a);
    mag37 = a[36] ? 36'(-a) : 36'(a);
  endfunction

  state_t              state_r, ret_r;
  logic [4:0]          idx_r;
  logic [1:0]          vi_r, vj_r;

  logic [15:0]         cd_r, rho_r;
  logic [23:0]         area_r;
  logic signed [31:0]  wind_r [3];
  logic [2:0]          dep_at_r;
  logic                dep_r;

  logic signed [31:0]  v_r [3];
  logic signed [31:0]  qw_r, qx_r, qy_r, qz_r;
  logic [63:0]         sum_r;
  logic [33:0]         rem_r;
  logic [31:0]         speed_r;
  logic [31:0]         kt_r;
  logic [32:0]         k_r;
  logic [62:0]         p_r;
  logic [46:0]         fpm_r [3];
  logic signed [33:0]  qp_r [9];
  logic [35:0]         rm_r [9];
  logic                rneg_r [9];
  logic signed [55:0]  facc_r;
  logic signed [47:0]  fb_r [3];

  logic [63:0]         prod_r;
  logic [1:0]          prod_off_r;
  logic                prod_vld_r;
  logic [95:0]         macc_r;

  logic                out_valid_r;
  qdf_pkg::out_word_t  out_data_r;

  logic                accept;
  logic                dep_new;
  logic [1:0]          vsel;
  logic signed [31:0]  v_cur;
  logic [31:0]         vmag;
  logic [3:0]          rsel;
  logic signed [31:0]  qa, qb;
  logic                qneg;
  logic [63:0]         a_op, b_op;
  logic                mul_go, multi, la, lb;
  logic [31:0]         a_limb, b_limb;
  logic [95:0]         shifted;
  logic [95:0]         macc_nxt;
  logic [35:0]         rem_t, trial;
  logic                sq_ge;
  logic [35:0]         rem_sub;
  logic [32:0]         qmag;
  logic signed [33:0]  qp_nxt;
  logic [46:0]         fpm_nxt;
  logic [52:0]         term;
  logic signed [55:0]  term_s;
  logic signed [55:0]  facc_nxt;
  logic signed [47:0]  fsat;
  logic signed [36:0]  e [9];
  logic signed [36:0]  r [9];
  logic                out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Latch update: a deploy command or a state code at or above the threshold sets it.
  assign dep_new = dep_r || in_data.kind || (in_data.vehicle_state >= dep_at_r);

  // Relative velocity lane select: one read port.
  always_comb begin
    unique case (state_r)
      S_SQ:    vsel = idx_r[1:0];
      S_P:     vsel = vi_r;
      default: vsel = vj_r;
    endcase
  end
  assign v_cur = v_r[vsel];
  assign vmag  = mag32(v_cur);

  // Rotation entry R[vj][vi] lives at 3*vj+vi.
  assign rsel = {vj_r, 1'b0} + {2'b00, vj_r} + {2'b00, vi_r};

  // Quaternion component pairs: xx yy zz xy xz yz wx wy wz.
  always_comb begin
    unique case (idx_r[3:0])
      4'd1:    begin qa = qy_r; qb = qy_r; end
      4'd2:    begin qa = qz_r; qb = qz_r; end
      4'd3:    begin qa = qx_r; qb = qy_r; end
      4'd4:    begin qa = qx_r; qb = qz_r; end
      4'd5:    begin qa = qy_r; qb = qz_r; end
      4'd6:    begin qa = qw_r; qb = qx_r; end
      4'd7:    begin qa = qw_r; qb = qy_r; end
      4'd8:    begin qa = qw_r; qb = qz_r; end
      default: begin qa = qx_r; qb = qx_r; end
    endcase
  end
  assign qneg = qa[31] ^ qb[31];

  // Operand select for the shared multiplier.
  always_comb begin
    a_op   = '0;
    b_op   = '0;
    mul_go = 1'b0;
    multi  = 1'b0;
    unique case (state_r)
      S_SQ: begin
        a_op = {32'b0, vmag}; b_op = {32'b0, vmag}; mul_go = 1'b1;
      end
      S_K1: begin
        a_op = {48'b0, rho_r}; b_op = {48'b0, cd_r}; mul_go = 1'b1;
      end
      S_K2: begin
        a_op = {32'b0, kt_r}; b_op = {40'b0, area_r}; mul_go = 1'b1;
      end
      S_P: begin
        a_op = {32'b0, speed_r}; b_op = {32'b0, vmag}; mul_go = 1'b1;
      end
      S_F: begin
        a_op = {31'b0, k_r}; b_op = {1'b0, p_r}; mul_go = 1'b1; multi = 1'b1;
      end
      S_Q: begin
        a_op = {32'b0, mag32(qa)}; b_op = {32'b0, mag32(qb)}; mul_go = 1'b1;
      end
      S_B: begin
        a_op = {28'b0, rm_r[rsel]}; b_op = {17'b0, fpm_r[vj_r]};
        mul_go = 1'b1; multi = 1'b1;
      end
      default: ;
    endcase
  end
  assign la     = multi && idx_r[1];
  assign lb     = multi && idx_r[0];
  assign a_limb = la ? a_op[63:32] : a_op[31:0];
  assign b_limb = lb ? b_op[63:32] : b_op[31:0];

  // Accumulate the registered product at its limb offset. The sum starts
  // from zero while idle and after each finished accumulation.
  always_comb begin
    unique case (prod_off_r)
      2'd0:    shifted = {32'b0, prod_r};
      2'd1:    shifted = {prod_r, 32'b0};
      2'd2:    shifted = {prod_r[31:0], 64'b0};
      default: shifted = '0;
    endcase
  end
  assign macc_nxt = ((state_r == S_END || state_r == S_IDLE) ? 96'b0 : macc_r) +
                    (prod_vld_r ? shifted : 96'b0);

  // One step of the digit-by-digit square root.
  assign rem_t   = {rem_r, sum_r[63:62]};
  assign trial   = {2'b00, speed_r, 2'b01};
  assign sq_ge   = (rem_t >= trial);
  assign rem_sub = rem_t - trial;

  // Quaternion product, truncated toward zero after the Q2.30 shift.
  assign qmag   = macc_r[62:30];
  assign qp_nxt = qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  // Parent-frame force magnitude, saturated to 2^47-1.
  assign fpm_nxt = (|macc_r[95:79]) ? MAX_MAG47 : macc_r[78:32];

  // Body-force term and running sum.
  assign term     = macc_r[82:30];
  assign term_s   = (rneg_r[rsel] ^ ~v_cur[31]) ? -$signed({3'b000, term})
                                                : $signed({3'b000, term});
  assign facc_nxt = facc_r + term_s;
  always_comb begin
    if (facc_nxt > 56'(MAX48)) begin
      fsat = MAX48;
    end else if (facc_nxt < 56'(MIN48)) begin
      fsat = MIN48;
    end else begin
      fsat = facc_nxt[47:0];
    end
  end

  // Rotation matrix from the stored component products.
  always_comb begin
    for (int n = 0; n < 9; n++) begin
      e[n] = 37'(qp_r[n]);
    end
    r[0] = ONE_Q30 - ((e[1] + e[2]) <<< 1);
    r[1] = (e[3] - e[8]) <<< 1;
    r[2] = (e[4] + e[7]) <<< 1;
    r[3] = (e[3] + e[8]) <<< 1;
    r[4] = ONE_Q30 - ((e[0] + e[2]) <<< 1);
    r[5] = (e[5] - e[6]) <<< 1;
    r[6] = (e[4] - e[7]) <<< 1;
    r[7] = (e[5] + e[6]) <<< 1;
    r[8] = ONE_Q30 - ((e[0] + e[1]) <<< 1);
  end

  // Sequencer, datapath registers and configuration.
  always_ff @(posedge clk) begin
    prod_r     <= a_limb * b_limb;
    prod_off_r <= {1'b0, la} + {1'b0, lb};
    macc_r     <= macc_nxt;

    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      idx_r       <= '0;
      vi_r        <= '0;
      vj_r        <= '0;
      dep_r       <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cd_r        <= qdf_pkg::RST_DRAG_COEFF;
      area_r      <= qdf_pkg::RST_REF_AREA;
      rho_r       <= qdf_pkg::RST_AIR_DENSITY;
      wind_r[0]   <= '0;
      wind_r[1]   <= '0;
      wind_r[2]   <= '0;
      dep_at_r    <= qdf_pkg::RST_DEPLOY_AT;
    end else begin
      prod_vld_r <= mul_go;

      // The output register empties when taken, unless a new word lands in it.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          qdf_pkg::CFG_DRAG_COEFF:  cd_r      <= cfg_wdata[15:0];
          qdf_pkg::CFG_REF_AREA:    area_r    <= cfg_wdata[23:0];
          qdf_pkg::CFG_AIR_DENSITY: rho_r     <= cfg_wdata[15:0];
          qdf_pkg::CFG_WIND_X:      wind_r[0] <= cfg_wdata;
          qdf_pkg::CFG_WIND_Y:      wind_r[1] <= cfg_wdata;
          qdf_pkg::CFG_WIND_Z:      wind_r[2] <= cfg_wdata;
          qdf_pkg::CFG_DEPLOY_AT:   dep_at_r  <= cfg_wdata[2:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            dep_r  <= dep_new;
            v_r[0] <= sub_sat(in_data.vel_x, wind_r[0]);
            v_r[1] <= sub_sat(in_data.vel_y, wind_r[1]);
            v_r[2] <= sub_sat(in_data.vel_z, wind_r[2]);
            qw_r   <= in_data.quat_w;
            qx_r   <= in_data.quat_x;
            qy_r   <= in_data.quat_y;
            qz_r   <= in_data.quat_z;
            idx_r  <= '0;
            if (dep_new) begin
              state_r <= S_SQ;
            end else begin
              fb_r[0] <= '0;
              fb_r[1] <= '0;
              fb_r[2] <= '0;
              state_r <= S_DONE;
            end
          end
        end

        // Sum of squared relative velocity components.
        S_SQ: begin
          if (idx_r == 5'd2) begin
            ret_r   <= S_SQ;
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end

        // One root bit per cycle.
        S_SQRT: begin
          sum_r <= {sum_r[61:0], 2'b00};
          if (sq_ge) begin
            rem_r   <= rem_sub[33:0];
            speed_r <= {speed_r[30:0], 1'b1};
          end else begin
            rem_r   <= rem_t[33:0];
            speed_r <= {speed_r[30:0], 1'b0};
          end
          if (idx_r == 5'd31) begin
            idx_r   <= '0;
            state_r <= S_K1;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end

        S_K1, S_K2, S_P: begin
          ret_r   <= state_r;
          state_r <= S_DRAIN;
        end

        // Four limb products each.
        S_F, S_B: begin
          if (idx_r == 5'd3) begin
            ret_r   <= state_r;
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end

        S_Q: begin
          ret_r   <= S_Q;
          state_r <= S_DRAIN;
        end

        // Rotation entries as magnitude and sign.
        S_R: begin
          for (int n = 0; n < 9; n++) begin
            rm_r[n]   <= mag37(r[n]);
            rneg_r[n] <= r[n][36];
          end
          facc_r  <= '0;
          vi_r    <= '0;
          vj_r    <= '0;
          idx_r   <= '0;
          state_r <= S_B;
        end

        S_DRAIN: begin
          state_r <= S_END;
        end

        // Take the finished accumulation.
        S_END: begin
          unique case (ret_r)
            S_SQ: begin
              sum_r   <= macc_r[63:0];
              rem_r   <= '0;
              speed_r <= '0;
              idx_r   <= '0;
              state_r <= S_SQRT;
            end
            S_K1: begin
              kt_r    <= macc_r[31:0];
              state_r <= S_K2;
            end
            S_K2: begin
              k_r     <= macc_r[55:23];
              vi_r    <= '0;
              state_r <= S_P;
            end
            S_P: begin
              p_r     <= macc_r[62:0];
              idx_r   <= '0;
              state_r <= S_F;
            end
            S_F: begin
              fpm_r[vi_r] <= fpm_nxt;
              idx_r       <= '0;
              if (vi_r == 2'd2) begin
                state_r <= S_Q;
              end else begin
                vi_r    <= vi_r + 2'd1;
                state_r <= S_P;
              end
            end
            S_Q: begin
              qp_r[idx_r[3:0]] <= qp_nxt;
              if (idx_r == 5'd8) begin
                state_r <= S_R;
              end else begin
                idx_r   <= idx_r + 5'd1;
                state_r <= S_Q;
              end
            end
            S_B: begin
              idx_r <= '0;
              if (vj_r == 2'd2) begin
                fb_r[vi_r] <= fsat;
                facc_r     <= '0;
                vj_r       <= '0;
                if (vi_r == 2'd2) begin
                  state_r <= S_DONE;
                end else begin
                  vi_r    <= vi_r + 2'd1;
                  state_r <= S_B;
                end
              end else begin
                facc_r  <= facc_nxt;
                vj_r    <= vj_r + 2'd1;
                state_r <= S_B;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end

        // Hand the word to the output register.
        S_DONE: begin
          if (out_free) begin
            out_data_r.force_x     <= fb_r[0];
            out_data_r.force_y     <= fb_r[1];
            out_data_r.force_z     <= fb_r[2];
            out_data_r.is_deployed <= dep_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted word makes the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("block idle after accepting a word");

  // The deploy latch never clears outside reset.
  assert property (@(posedge clk) disable iff (!rst_n) dep_r |=> dep_r)
    else $error("deploy latch cleared");

  // A word without deployment carries zero force.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_deployed) |->
      (out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0))
    else $error("force without deployment");

  // The multiplier pipeline is empty whenever the block is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !prod_vld_r)
    else $error("product pending while idle");
`endif

endmodule
